// File: rtl/rai_pkg.sv
// Shared types, codes and constants for the ray/annulus intersection block.
package rai_pkg;

    // Result status codes
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;
    localparam logic [2:0] REG_INNER    = 3'd6;
    localparam logic [2:0] REG_OUTER    = 3'd7;

    localparam logic [31:0] NORMAL_Z_RESET = 32'h4000_0000;

    // Quotient bits produced by the divider, one per stage
    localparam int QBITS = 32;

    typedef logic signed [31:0] fix_t;

    typedef struct packed {
        fix_t [2:0]  c;
        fix_t [2:0]  n;
        logic [61:0] rin_sq;
        logic [61:0] rout_sq;
    } cfg_t;

    typedef struct packed {
        fix_t [2:0] o;
        fix_t [2:0] d;
    } ray_t;

    // Plane stage result handed to the divider
    typedef struct packed {
        ray_t        ray;
        logic [61:0] an;
        logic [60:0] ad;
        logic        neg;
        logic        par;
        logic        big;
    } div_in_t;

    // Sideband that rides along the divider stages
    typedef struct packed {
        ray_t        ray;
        logic [60:0] ad;
        logic [15:0] alo;
        logic        neg;
        logic        par;
        logic        big;
    } div_side_t;

    typedef struct packed {
        ray_t        ray;
        logic [31:0] q;
        logic        neg;
        logic        par;
        logic        big;
    } div_out_t;

    typedef struct packed {
        logic [1:0] status;
        fix_t       t;
        fix_t [2:0] p;
    } result_t;

endpackage

// File: rtl/rai_cfg.sv
// Configuration registers and squared radii.
module rai_cfg
    import rai_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    fix_t [2:0]  c_reg;
    fix_t [2:0]  n_reg;
    logic [30:0] rin_reg;
    logic [30:0] rout_reg;
    logic [61:0] rin_sq_reg;
    logic [61:0] rout_sq_reg;

    // Write one register per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg    <= '0;
            n_reg    <= {NORMAL_Z_RESET, 32'd0, 32'd0};
            rin_reg  <= '0;
            rout_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: c_reg[0] <= cfg_data;
                REG_CENTER_Y: c_reg[1] <= cfg_data;
                REG_CENTER_Z: c_reg[2] <= cfg_data;
                REG_NORMAL_X: n_reg[0] <= cfg_data;
                REG_NORMAL_Y: n_reg[1] <= cfg_data;
                REG_NORMAL_Z: n_reg[2] <= cfg_data;
                REG_INNER:    rin_reg  <= cfg_data[30:0];
                REG_OUTER:    rout_reg <= cfg_data[30:0];
                default:      c_reg[0] <= c_reg[0];
            endcase
        end
    end

    // Square the radii once per cycle; settles while the block is idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rin_sq_reg  <= '0;
            rout_sq_reg <= '0;
        end
        else
        begin
            rin_sq_reg  <= rin_reg * rin_reg;
            rout_sq_reg <= rout_reg * rout_reg;
        end
    end

    assign cfg.c       = c_reg;
    assign cfg.n       = n_reg;
    assign cfg.rin_sq  = rin_sq_reg;
    assign cfg.rout_sq = rout_sq_reg;

endmodule

// File: rtl/rai_plane.sv
// Plane stages: dot products of the normal, numerator and denominator magnitudes.
module rai_plane
    import rai_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  cfg_t    cfg,
    input  logic    in_v,
    input  ray_t    in_ray,
    output logic    out_v,
    output div_in_t out_d
);

    logic [3:0] v_reg;

    ray_t              ray1_reg, ray2_reg, ray3_reg;
    logic signed [32:0] diff_reg [3];
    logic signed [64:0] pn_reg [3];
    logic signed [63:0] pd_reg [3];
    logic signed [62:0] num_reg;
    logic signed [61:0] den_reg;
    div_in_t           out_reg;

    logic signed [62:0] num_next;
    logic signed [61:0] den_next;
    div_in_t           out_next;
    logic [62:0]       num_neg;
    logic [61:0]       den_neg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_v};
    end

    // Sum floored products
    always_comb
    begin
        num_next = '0;
        den_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            num_next = num_next + {pn_reg[i][64], pn_reg[i][64:3]};
            den_next = den_next + {pd_reg[i][63], pd_reg[i][63:3]};
        end
    end

    // Magnitudes, sign and range checks
    always_comb
    begin
        num_neg        = -num_reg;
        den_neg        = -den_reg;
        out_next.ray   = ray3_reg;
        out_next.neg   = num_reg[62] ^ den_reg[61];
        out_next.an    = num_reg[62] ? num_neg[61:0] : num_reg[61:0];
        out_next.ad    = den_reg[61] ? den_neg[60:0] : den_reg[60:0];
        out_next.par   = (den_reg == '0);
        out_next.big   = ({15'd0, out_next.an} >= {out_next.ad, 16'd0});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray1_reg <= in_ray;
            for (int i = 0; i < 3; i++)
                diff_reg[i] <= {cfg.c[i][31], cfg.c[i]} - {in_ray.o[i][31], in_ray.o[i]};
            ray2_reg <= ray1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pn_reg[i] <= $signed(cfg.n[i]) * diff_reg[i];
                pd_reg[i] <= $signed(cfg.n[i]) * $signed(ray1_reg.d[i]);
            end
            ray3_reg <= ray2_reg;
            num_reg  <= num_next;
            den_reg  <= den_next;
            out_reg  <= out_next;
        end
    end

    assign out_v = v_reg[3];
    assign out_d = out_reg;

endmodule

// File: rtl/rai_div.sv
// Restoring divider, one quotient bit per pipeline stage.
module rai_div
    import rai_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_v,
    input  div_in_t  in_d,
    output logic     out_v,
    output div_out_t out_d
);

    logic [QBITS:0] v_reg;
    logic [60:0]    rem_reg  [QBITS+1];
    logic [31:0]    q_reg    [QBITS+1];
    div_side_t      side_reg [QBITS+1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[QBITS-1:0], in_v};
    end

    // Load: high dividend bits form the first partial remainder
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]       <= {15'd0, in_d.an[61:16]};
            q_reg[0]         <= '0;
            side_reg[0].ray  <= in_d.ray;
            side_reg[0].ad   <= in_d.ad;
            side_reg[0].alo  <= in_d.an[15:0];
            side_reg[0].neg  <= in_d.neg;
            side_reg[0].par  <= in_d.par;
            side_reg[0].big  <= in_d.big;
        end
    end

    // One trial subtraction per stage
    for (genvar j = 0; j < QBITS; j++)
    begin : g_step
        localparam int K = QBITS - 1 - j;
        logic        nb;
        logic [61:0] cand;
        logic [62:0] diff;
        logic        ge;

        if (K >= 16)
        begin : g_hi
            assign nb = side_reg[j].alo[K-16];
        end
        else
        begin : g_lo
            assign nb = 1'b0;
        end

        assign cand = {rem_reg[j], nb};
        assign diff = {1'b0, cand} - {2'b00, side_reg[j].ad};
        assign ge   = ~diff[62];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1]  <= ge ? diff[60:0] : cand[60:0];
                q_reg[j+1]    <= {q_reg[j][30:0], ge};
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_v     = v_reg[QBITS];
    assign out_d.ray = side_reg[QBITS].ray;
    assign out_d.q   = q_reg[QBITS];
    assign out_d.neg = side_reg[QBITS].neg;
    assign out_d.par = side_reg[QBITS].par;
    assign out_d.big = side_reg[QBITS].big;

endmodule

// File: rtl/rai_point.sv
// Point stages: signed t, hit point, squared distance and annulus test.
module rai_point
    import rai_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  cfg_t     cfg,
    input  logic     in_v,
    input  div_out_t in_d,
    output logic     out_v,
    output result_t  out_r
);

    logic [5:0] v_reg;

    // Stage 1
    fix_t       t1_reg;
    ray_t       ray1_reg;
    logic       par1_reg, ovf1_reg;
    // Stage 2
    fix_t               t2_reg;
    ray_t               ray2_reg;
    logic               par2_reg, ovf2_reg;
    logic signed [63:0] prod_reg [3];
    // Stage 3
    fix_t       t3_reg;
    fix_t [2:0] p3_reg;
    logic       par3_reg, ovf3_reg;
    // Stage 4
    fix_t        t4_reg;
    fix_t [2:0]  p4_reg;
    logic        par4_reg, ovf4_reg, far4_reg;
    logic [30:0] mag_reg [3];
    // Stage 5
    fix_t        t5_reg;
    fix_t [2:0]  p5_reg;
    logic        par5_reg, ovf5_reg, far5_reg;
    logic [61:0] sq_reg [3];
    // Output
    result_t     out_reg;

    logic [31:0] lim;
    logic [31:0] q_neg;
    logic        ovf1_next;
    logic [48:0] p49 [3];
    logic        ovfp;
    logic [32:0] dd  [3];
    logic [32:0] mag [3];
    logic        far_next;
    logic [63:0] dist2;
    logic        in_ring;
    result_t     out_next;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[4:0], in_v};
    end

    // Range check of the quotient
    always_comb
    begin
        lim       = in_d.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q_neg     = -in_d.q;
        ovf1_next = in_d.big | (in_d.q > lim);
    end

    // Add origin to floored t*d and check the range
    always_comb
    begin
        ovfp = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            p49[i] = {{17{ray2_reg.o[i][31]}}, ray2_reg.o[i]}
                   + {prod_reg[i][63], prod_reg[i][63:16]};
            if (p49[i][48:31] != {18{p49[i][31]}})
                ovfp = 1'b1;
        end
    end

    // Distance components from the center
    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dd[i]  = {p3_reg[i][31], p3_reg[i]} - {cfg.c[i][31], cfg.c[i]};
            mag[i] = dd[i][32] ? -dd[i] : dd[i];
            if (mag[i][32] | mag[i][31])
                far_next = 1'b1;
        end
    end

    // Annulus test and final status
    always_comb
    begin
        dist2   = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        in_ring = ~far5_reg && (dist2 <= {2'b00, cfg.rout_sq})
                            && (dist2 >= {2'b00, cfg.rin_sq});
        out_next.t = t5_reg;
        out_next.p = p5_reg;
        if (in_ring)
            out_next.status = ST_HIT;
        else
            out_next.status = ST_OUTSIDE;
        priority if (par5_reg)
        begin
            out_next.status = ST_PARALLEL;
            out_next.t      = '0;
            out_next.p      = '0;
        end
        else if (ovf5_reg)
        begin
            out_next.status = ST_OVERFLOW;
            out_next.t      = '0;
            out_next.p      = '0;
        end
        else
        begin
            out_next.t = t5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= in_d.neg ? q_neg : in_d.q;
            ray1_reg <= in_d.ray;
            par1_reg <= in_d.par;
            ovf1_reg <= ovf1_next;

            t2_reg   <= t1_reg;
            ray2_reg <= ray1_reg;
            par2_reg <= par1_reg;
            ovf2_reg <= ovf1_reg;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= t1_reg * ray1_reg.d[i];

            t3_reg   <= t2_reg;
            par3_reg <= par2_reg;
            ovf3_reg <= ovf2_reg | ovfp;
            for (int i = 0; i < 3; i++)
                p3_reg[i] <= p49[i][31:0];

            t4_reg   <= t3_reg;
            p4_reg   <= p3_reg;
            par4_reg <= par3_reg;
            ovf4_reg <= ovf3_reg;
            far4_reg <= far_next;
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= mag[i][30:0];

            t5_reg   <= t4_reg;
            p5_reg   <= p4_reg;
            par5_reg <= par4_reg;
            ovf5_reg <= ovf4_reg;
            far5_reg <= far4_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= mag_reg[i] * mag_reg[i];

            out_reg <= out_next;
        end
    end

    assign out_v = v_reg[5];
    assign out_r = out_reg;

endmodule

// File: rtl/ray_annulus_intersection_top.sv
// Top level of the ray/annulus intersection pipeline.
//
// Input channel: in_valid with origin_* and dir_*, Q16.16; a beat is taken
// when in_valid is high and in_stall is low. Output channel: out_valid with
// status, hit_t and hit_x..hit_z; a beat leaves when out_valid is high and
// out_stall is low. Configuration: cfg_we writes cfg_data to register
// cfg_index; the user must write only while no ray is in flight, as the
// block itself does not enforce it. Throughput: one ray per cycle while
// not stalled. Stages: 4 plane stages (dot products and magnitudes), 33
// divider stages (one quotient bit each) and 6 point stages (t*d multiply,
// distance squares, annulus compare and output register).
// The whole pipeline moves as one: while the output register holds an
// unaccepted beat and out_stall is high, every stage holds and in_stall is
// raised; nothing is lost or repeated. An empty output register never stalls.
// Reset clears all valid bits and loads the default plane (normal along z,
// center at the origin, both radii zero).
module ray_annulus_intersection_top
    import rai_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic signed [31:0] hit_t,
    output logic signed [31:0] hit_x,
    output logic signed [31:0] hit_y,
    output logic signed [31:0] hit_z
);

    cfg_t     cfg;
    ray_t     ray;
    logic     adv;
    logic     pl_v, dv_v;
    div_in_t  pl_d;
    div_out_t dv_d;
    result_t  res;

    // Hold every stage while a finished beat waits
    assign adv      = ~out_valid | ~out_stall;
    assign in_stall = ~adv;

    assign ray.o = {origin_z, origin_y, origin_x};
    assign ray.d = {dir_z, dir_y, dir_x};

    rai_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rai_plane u_plane (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .cfg    (cfg),
        .in_v   (in_valid),
        .in_ray (ray),
        .out_v  (pl_v),
        .out_d  (pl_d)
    );

    rai_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .in_v  (pl_v),
        .in_d  (pl_d),
        .out_v (dv_v),
        .out_d (dv_d)
    );

    rai_point u_point (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cfg   (cfg),
        .in_v  (dv_v),
        .in_d  (dv_d),
        .out_v (out_valid),
        .out_r (res)
    );

    assign status = res.status;
    assign hit_t  = res.t;
    assign hit_x  = res.p[0];
    assign hit_y  = res.p[1];
    assign hit_z  = res.p[2];

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the ray/annulus intersection pipeline.
module testbench;
    import rai_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_CENTER_X;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic signed [31:0] hit_t, hit_x, hit_y, hit_z;

    ray_t        cur_ray = '0;
    ray_t        ray_q[$];
    result_t     crossing_q[$];
    logic signed [31:0] ctr[3];
    logic signed [31:0] nrm[3];
    logic [30:0] rin, rout;
    logic        beat_sent = 1'b0;
    logic        quiet = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          err_count = 0;
    int          cycle_count = 0;

    ray_annulus_intersection_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(cur_ray.o[0]), .origin_y(cur_ray.o[1]), .origin_z(cur_ray.o[2]),
        .dir_x(cur_ray.d[0]), .dir_y(cur_ray.d[1]), .dir_z(cur_ray.d[2]),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit_t(hit_t), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
    );

    always #6 clk = ~clk;

    // Work out the plane crossing and annulus verdict for one ray
    function automatic result_t plane_crossing(ray_t r);
        result_t res;
        logic signed [127:0] num, den, a, b, tq, p;
        logic [127:0] an, ad, mag, v, dist2, lim;
        logic neg, in_ring;
        res = '0;
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = nrm[i];
            b = ctr[i];
            p = r.o[i];
            b = b - p;
            num = num + ((a * b) >>> 3);
            b = r.d[i];
            den = den + ((a * b) >>> 3);
        end
        if (den == 0)
        begin
            res.status = ST_PARALLEL;
            return res;
        end
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        mag = (an << 16) / ad;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (mag > lim)
        begin
            res.status = ST_OVERFLOW;
            return res;
        end
        tq = neg ? -$signed(mag) : $signed(mag);
        res.t = tq[31:0];
        in_ring = 1'b1;
        dist2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            b = r.d[i];
            a = r.o[i];
            p = a + ((tq * b) >>> 16);
            if (p < -128'sh8000_0000 || p > 128'sh7fff_ffff)
            begin
                res = '0;
                res.status = ST_OVERFLOW;
                return res;
            end
            res.p[i] = p[31:0];
            a = ctr[i];
            a = p - a;
            v = (a < 0) ? -a : a;
            if (v >= 128'h8000_0000)
                in_ring = 1'b0;
            else
                dist2 = dist2 + v * v;
        end
        an = rin;
        ad = rout;
        if (in_ring)
            in_ring = dist2 <= ad * ad && dist2 >= an * an;
        res.status = in_ring ? ST_HIT : ST_OUTSIDE;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        err_count++;
    endtask

    // Drive rays at the falling edge, holding a stalled beat, and drive random output stalls
    always @(negedge clk)
    begin
        if (!in_valid || beat_sent)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (ray_q.size() > 0)
            begin
                cur_ray <= ray_q.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 6);
            end
            else
                in_valid <= 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Predict accepted beats, check delivered beats, watch the time limit
    always @(posedge clk)
    begin
        result_t want;
        cycle_count <= cycle_count + 1;
        beat_sent <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            crossing_q.push_back(plane_crossing(cur_ray));
        if (rst_n && out_valid && !out_stall)
        begin
            if (crossing_q.size() == 0)
            begin
                $display("mismatch: result beat with nothing expected");
                err_count++;
            end
            else
            begin
                want = crossing_q.pop_front();
                if (status !== want.status) report("status", status, want.status);
                if (hit_t !== want.t) report("hit_t", hit_t, want.t);
                if (hit_x !== want.p[0]) report("hit_x", hit_x, want.p[0]);
                if (hit_y !== want.p[1]) report("hit_y", hit_y, want.p[1]);
                if (hit_z !== want.p[2]) report("hit_z", hit_z, want.p[2]);
            end
        end
        if (cycle_count > 300000)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx <= REG_CENTER_Z)
            ctr[idx] = val;
        else if (idx <= REG_NORMAL_Z)
            nrm[idx - REG_NORMAL_X] = val;
        else if (idx == REG_INNER)
            rin = val[30:0];
        else
            rout = val[30:0];
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (ray_q.size() == 0 && !in_valid && crossing_q.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
        r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
        ray_q.push_back(r);
    endtask

    // Mostly rays aimed near the ring, some fully random
    task automatic add_random_ray();
        ray_t r;
        longint tgt, k, dd;
        k = $urandom_range(0, 8);
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r.o[i] = $urandom;
                r.d[i] = $urandom;
            end
            else
            begin
                dd = $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
                tgt = longint'(ctr[i]) + $signed(32'($urandom_range(0, 1 << 21)))
                      - (1 << 20);
                r.d[i] = 32'(dd);
                r.o[i] = 32'(tgt - k * dd);
            end
        end
        ray_q.push_back(r);
    endtask

    initial
    begin
        ctr = '{0, 0, 0};
        nrm = '{0, 0, 32'sh4000_0000};
        rin = '0;
        rout = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset plane: parallel, exact center hit, overflow of t and point
        add_ray(0, 0, 65536, 65536, 0, 0);
        add_ray(0, 0, 65536, 0, 0, -65536);
        add_ray(0, 0, 32'h7fff_ffff, 0, 0, 1);
        add_ray(32'h7fff_ffff, 0, -65536, 32'h7fff_ffff, 0, 65536);
        add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -1, -1, -1);
        add_ray(0, 0, 65536, 0, 0, 32'h8000_0000);
        add_ray(65536, 0, 131072, 0, 0, 65536);
        add_ray(0, 0, 0, 0, 0, 0);
        drain();

        // Extremes of every register, radii out of order first
        write_reg(REG_CENTER_X, 32'h7fff_ffff);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_CENTER_Z, 32'h0);
        write_reg(REG_NORMAL_X, 32'h8000_0000);
        write_reg(REG_NORMAL_Y, 32'h7fff_ffff);
        write_reg(REG_NORMAL_Z, 32'h0);
        write_reg(REG_INNER, 32'hffff_ffff);
        write_reg(REG_OUTER, 32'h0);
        end_writes();
        add_ray(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 65536);
        add_ray(0, 0, 0, 65536, 65536, 0);
        add_ray(32'h7fff_0000, 32'h8001_0000, 5, -65536, 0, 1);
        add_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff);
        drain();
        write_reg(REG_INNER, 32'h0);
        write_reg(REG_OUTER, 32'h7fff_ffff);
        end_writes();
        add_ray(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 65536);
        add_ray(32'h7fff_0000, 32'h8001_0000, 5, -65536, 0, 1);
        for (int i = 0; i < 20; i++)
            add_random_ray();
        drain();

        // Random planes, mostly axis aligned, last phase without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            int ax;
            ax = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
            begin
                write_reg(3'(REG_CENTER_X + i),
                          32'($signed(32'($urandom_range(0, 1 << 25))) - (1 << 24)));
                if (ph == 5)
                    write_reg(3'(REG_NORMAL_X + i), $urandom);
                else if (i == ax)
                    write_reg(3'(REG_NORMAL_X + i), $urandom_range(0, 1) ? 32'h4000_0000
                                                                        : 32'hc000_0000);
                else
                    write_reg(3'(REG_NORMAL_X + i), 32'h0);
            end
            write_reg(REG_INNER, $urandom_range(0, 1 << 19));
            write_reg(REG_OUTER, 32'(rin) + $urandom_range(0, 1 << 21));
            end_writes();
            if (ph == 7)
                quiet = 1'b1;
            for (int i = 0; i < 100; i++)
                add_random_ray();
            drain();
        end

        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
